// File: rtl/rbst_pkg.sv
`timescale 1ns / 1ps
package rbst_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW        = 32;                 // data width of every data field
  localparam int NW        = DW + 1 + FRAC_BITS; // dividend magnitude width
  localparam int RW        = 2 * DW;             // remainder / shifted divisor width
  localparam int BITS_PER_STG = 2;
  localparam int DIV_STG   = DW / BITS_PER_STG;
  localparam int DIV_LAT   = DIV_STG + 2;        // input reg + steps + saturate reg
  localparam int IDX_W     = 3;

  localparam logic [IDX_W-1:0] REG_MIN_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_MIN_Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_MIN_Z = 3'd2;
  localparam logic [IDX_W-1:0] REG_MAX_X = 3'd3;
  localparam logic [IDX_W-1:0] REG_MAX_Y = 3'd4;
  localparam logic [IDX_W-1:0] REG_MAX_Z = 3'd5;

  localparam logic signed [DW-1:0] Q_POS_INF = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] Q_NEG_INF = {1'b1, {(DW-1){1'b0}}};

  typedef struct packed {
    logic                 vld;
    logic                 empty;
    logic                 in_box;
    logic                 zmiss;
    logic [2:0]           dz;
    logic signed [DW-1:0] lim;
  } sb_t;

endpackage

// File: rtl/rbst_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, magnitude in, signed saturated quotient out.
module rbst_div import rbst_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [NW-1:0]        n_i,
  input  logic [DW-1:0]        d_i,
  input  logic                 neg_i,
  output logic signed [DW-1:0] q_o
);

  logic [RW-1:0] r_q [0:DIV_STG];
  logic [RW-1:0] d_q [0:DIV_STG];
  logic [DW-1:0] qt_q [0:DIV_STG];
  logic          neg_q [0:DIV_STG];
  logic          ovf_q [0:DIV_STG];
  logic signed [DW-1:0] q_d, q_q;
  logic [RW-1:0] n_ext, d_ext;

  assign n_ext = {{(RW-NW){1'b0}}, n_i};
  assign d_ext = {{(RW-DW){1'b0}}, d_i};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= n_ext;
      d_q[0]   <= d_ext;
      qt_q[0]  <= '0;
      neg_q[0] <= neg_i;
      ovf_q[0] <= n_ext >= (d_ext << (DW - 1));  // magnitude of 2^31 or more
    end
  end

  for (genvar s = 1; s <= DIV_STG; s++) begin : g_stg
    logic [RW-1:0] r_d;
    logic [DW-1:0] qt_d;

    always_comb begin : step
      logic [RW-1:0] dk;
      int            k;
      r_d  = r_q[s-1];
      qt_d = qt_q[s-1];
      for (int j = 0; j < BITS_PER_STG; j++) begin
        k  = DW - 1 - ((s - 1) * BITS_PER_STG + j);
        dk = d_q[s-1] << k;
        if (r_d >= dk) begin
          r_d     = r_d - dk;
          qt_d[k] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s]   <= r_d;
        d_q[s]   <= d_q[s-1];
        qt_q[s]  <= qt_d;
        neg_q[s] <= neg_q[s-1];
        ovf_q[s] <= ovf_q[s-1];
      end
    end
  end

  always_comb begin
    if (ovf_q[DIV_STG]) begin
      q_d = neg_q[DIV_STG] ? Q_NEG_INF : Q_POS_INF;
    end else if (neg_q[DIV_STG]) begin
      q_d = -$signed(qt_q[DIV_STG]);
    end else begin
      q_d = $signed(qt_q[DIV_STG]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

// File: rtl/ray_box_slab_test_unit.sv
`timescale 1ns / 1ps
// Ray against axis-aligned box, slab test.
// The box corners sit in six registers written through cfg_we_i / cfg_idx_i /
// cfg_data_i (min x,y,z at 0..2, max x,y,z at 3..5; other indexes ignored).
// Write them only while no ray is in flight. Reset leaves an empty box.
// Rays enter on in_valid_i / in_ready_o with origin, direction and t_limit;
// each beat yields one hit_o beat on out_valid_o / out_ready_i.
// Pipeline stages: input stage, 16 stages of the six parallel dividers at two
// quotient bits each, saturation, slab ordering, intersection. Throughput:
// one ray per cycle while the output is not stalled.
// The pipeline advances as one: when the output beat is held by
// out_ready_i low, every stage holds and in_ready_o drops; nothing is lost
// or repeated. Reset clears all valid bits and empties the box registers.
module ray_box_slab_test_unit import rbst_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [IDX_W-1:0]     cfg_idx_i,
  input  logic [DW-1:0]        cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [DW-1:0] origin_x_i,
  input  logic signed [DW-1:0] origin_y_i,
  input  logic signed [DW-1:0] origin_z_i,
  input  logic signed [DW-1:0] dir_x_i,
  input  logic signed [DW-1:0] dir_y_i,
  input  logic signed [DW-1:0] dir_z_i,
  input  logic signed [DW-1:0] t_limit_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 hit_o
);

  logic signed [DW-1:0] box_min_q [3];
  logic signed [DW-1:0] box_max_q [3];
  logic signed [DW-1:0] org [3];
  logic signed [DW-1:0] dir [3];
  logic                 en;
  logic                 empty;
  logic                 in_box;
  sb_t                  sb_d;
  sb_t                  sb_q [DIV_LAT];
  logic signed [DW-1:0] qlo [3];
  logic signed [DW-1:0] qhi [3];
  logic signed [DW-1:0] ent_d [3], ext_d [3], ent_q [3], ext_q [3];
  sb_t                  o1_sb_q;
  logic                 hit_d, hit_q, out_vld_q;

  assign en = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        box_min_q[a] <= Q_POS_INF;
        box_max_q[a] <= Q_NEG_INF;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MIN_X: box_min_q[0] <= cfg_data_i;
        REG_MIN_Y: box_min_q[1] <= cfg_data_i;
        REG_MIN_Z: box_min_q[2] <= cfg_data_i;
        REG_MAX_X: box_max_q[0] <= cfg_data_i;
        REG_MAX_Y: box_max_q[1] <= cfg_data_i;
        REG_MAX_Z: box_max_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign org[0] = origin_x_i;
  assign org[1] = origin_y_i;
  assign org[2] = origin_z_i;
  assign dir[0] = dir_x_i;
  assign dir[1] = dir_y_i;
  assign dir[2] = dir_z_i;

  always_comb begin
    empty  = 1'b0;
    in_box = 1'b1;
    sb_d   = '0;
    for (int a = 0; a < 3; a++) begin
      if (box_min_q[a] > box_max_q[a]) empty = 1'b1;
      if (box_min_q[a] > org[a] || box_max_q[a] < org[a]) in_box = 1'b0;
      sb_d.dz[a] = (dir[a] == '0);
      if (sb_d.dz[a] && (org[a] < box_min_q[a] || org[a] > box_max_q[a])) begin
        sb_d.zmiss = 1'b1;
      end
    end
    sb_d.vld    = in_valid_i;
    sb_d.empty  = empty;
    sb_d.in_box = in_box;
    sb_d.lim    = t_limit_i;
  end

  // six dividers: (bound - origin) << FRAC_BITS / dir, per axis and side
  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic signed [DW:0]   dlo, dhi;
    logic signed [NW-1:0] nlo, nhi;
    logic [NW-1:0]        mlo, mhi;
    logic [DW-1:0]        dmag;

    assign dlo  = {box_min_q[a][DW-1], box_min_q[a]} - {org[a][DW-1], org[a]};
    assign dhi  = {box_max_q[a][DW-1], box_max_q[a]} - {org[a][DW-1], org[a]};
    assign nlo  = {dlo, {FRAC_BITS{1'b0}}};
    assign nhi  = {dhi, {FRAC_BITS{1'b0}}};
    assign mlo  = nlo[NW-1] ? -nlo : nlo;
    assign mhi  = nhi[NW-1] ? -nhi : nhi;
    assign dmag = dir[a][DW-1] ? -dir[a] : dir[a];

    rbst_div u_div_lo (
      .clk_i (clk_i),
      .en_i  (en),
      .n_i   (mlo),
      .d_i   (dmag),
      .neg_i (nlo[NW-1] ^ dir[a][DW-1]),
      .q_o   (qlo[a])
    );

    rbst_div u_div_hi (
      .clk_i (clk_i),
      .en_i  (en),
      .n_i   (mhi),
      .d_i   (dmag),
      .neg_i (nhi[NW-1] ^ dir[a][DW-1]),
      .q_o   (qhi[a])
    );
  end

  // side band travels alongside the dividers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DIV_LAT; s++) sb_q[s] <= '0;
    end else if (en) begin
      sb_q[0] <= sb_d;
      for (int s = 1; s < DIV_LAT; s++) sb_q[s] <= sb_q[s-1];
    end
  end

  // order entry/exit per axis; zero direction means unbounded slab
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (sb_q[DIV_LAT-1].dz[a]) begin
        ent_d[a] = Q_NEG_INF;
        ext_d[a] = Q_POS_INF;
      end else if (qlo[a] > qhi[a]) begin
        ent_d[a] = qhi[a];
        ext_d[a] = qlo[a];
      end else begin
        ent_d[a] = qlo[a];
        ext_d[a] = qhi[a];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o1_sb_q <= '0;
    end else if (en) begin
      o1_sb_q <= sb_q[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ent_q <= ent_d;
      ext_q <= ext_d;
    end
  end

  always_comb begin : isect
    logic signed [DW-1:0] tmin, tmax;
    logic                 c1, c2;
    c1   = (ent_q[0] <= ext_q[1]) && (ent_q[1] <= ext_q[0]);
    tmin = (ent_q[0] > ent_q[1]) ? ent_q[0] : ent_q[1];
    tmax = (ext_q[0] < ext_q[1]) ? ext_q[0] : ext_q[1];
    c2   = (tmin <= ext_q[2]) && (ent_q[2] <= tmax);
    if (ent_q[2] > tmin) tmin = ent_q[2];
    if (ext_q[2] < tmax) tmax = ext_q[2];
    hit_d = !o1_sb_q.empty &&
            (o1_sb_q.in_box ||
             (!o1_sb_q.zmiss && c1 && c2 && tmin <= tmax &&
              tmin > 0 && tmin < o1_sb_q.lim));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= o1_sb_q.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= hit_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign hit_o       = hit_q;

  // user must keep box stable in flight (not enforced); empty box never hits
  a_empty_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && empty |-> !hit_o)
    else $error("hit reported against an empty box");

  a_in_box_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && o1_sb_q.vld && o1_sb_q.in_box && !o1_sb_q.empty |=> out_valid_o && hit_o)
    else $error("origin inside box did not hit");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(o1_sb_q) && $stable(sb_q[DIV_LAT-1]))
    else $error("pipeline moved during stall");

endmodule
